### hw/rtl/bcpf_pkg.sv
// ----------------------------------------------------------------------------
// bcpf_pkg
// Shared types and constants of the banded color pixel filter.
// ----------------------------------------------------------------------------
package bcpf_pkg;

	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned FILT_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 13;
	localparam int unsigned DIM_W     = 13;

	localparam int unsigned GRAY_B_K   = 20;
	localparam int unsigned GRAY_G_K   = 50;
	localparam int unsigned GRAY_R_K   = 30;
	localparam int unsigned GRAY_SUM_W = 15;
	// floor(s / 100) == (s * 20972) >> 21 for every s below 25600
	localparam int unsigned GRAY_RECIP = 20972;
	localparam int unsigned GRAY_SHIFT = 21;
	localparam int unsigned GRAY_PROD_W = 2 * GRAY_SUM_W;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_FILTER  = 2'd0,
		REG_BAND_WIDTH    = 2'd1,
		REG_FILTER_WEIGHT = 2'd2,
		REG_IMAGE_WIDTH   = 2'd3
	} cfg_reg_t;

	typedef enum logic [FILT_W-1:0] {
		FILT_GRAY  = 2'd0,
		FILT_BLUE  = 2'd1,
		FILT_GREEN = 2'd2,
		FILT_RED   = 2'd3
	} filt_t;

	typedef struct packed {
		filt_t filter;
		logic  last;
	} band_info_t;

endpackage

### hw/rtl/bcpf_band_track.sv
// ----------------------------------------------------------------------------
// bcpf_band_track
// Column, band position and band filter tracking across each row.
// ----------------------------------------------------------------------------
module bcpf_band_track import bcpf_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                ff_wr,
	input  logic [FILT_W-1:0]   ff_data,
	input  logic [FILT_W-1:0]   first_filter,
	input  logic [DIM_W-1:0]    band_width,
	input  logic [DIM_W-1:0]    image_width,
	output band_info_t          info
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

	logic [CW-1:0]     col_q;
	logic [CW-1:0]     pos_q;
	logic [FILT_W-1:0] filt_q;
	logic [CMPW-1:0]   iw_raw;
	logic [CMPW-1:0]   iw_eff;
	logic [CMPW-1:0]   bw_eff;
	logic [CMPW-1:0]   col_nxt;
	logic [CMPW-1:0]   pos_nxt;
	logic              last;
	logic              band_end;

	always_comb begin
		iw_raw = CMPW'(image_width);
		if (iw_raw == '0) begin
			iw_eff = CMPW'(1);
		end else if (iw_raw > CMPW'(MAX_WIDTH)) begin
			iw_eff = CMPW'(MAX_WIDTH);
		end else begin
			iw_eff = iw_raw;
		end
		bw_eff   = (band_width == '0) ? CMPW'(1) : CMPW'(band_width);
		col_nxt  = CMPW'(col_q) + CMPW'(1);
		pos_nxt  = CMPW'(pos_q) + CMPW'(1);
		last     = (col_nxt >= iw_eff);
		band_end = (pos_nxt >= bw_eff);
	end

	assign info.filter = filt_t'(filt_q);
	assign info.last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			pos_q  <= '0;
			filt_q <= '0;
		end else if (advance) begin
			if (last) begin
				col_q  <= '0;
				pos_q  <= '0;
				filt_q <= first_filter;
			end else begin
				col_q <= col_nxt[CW-1:0];
				if (band_end) begin
					pos_q  <= '0;
					filt_q <= filt_q + FILT_W'(1);
				end else begin
					pos_q <= pos_nxt[CW-1:0];
				end
			end
		end else if (ff_wr && col_q == '0) begin
			filt_q <= ff_data;
		end
	end

endmodule

### hw/rtl/bcpf_color.sv
// ----------------------------------------------------------------------------
// bcpf_color
// Per-pixel gray or channel boost according to the band filter.
// ----------------------------------------------------------------------------
module bcpf_color import bcpf_pkg::*; (
	input  filt_t               filter,
	input  logic [CHAN_W-1:0]   weight,
	input  logic [CHAN_W-1:0]   blue,
	input  logic [CHAN_W-1:0]   green,
	input  logic [CHAN_W-1:0]   red,
	output logic [CHAN_W-1:0]   res_blue,
	output logic [CHAN_W-1:0]   res_green,
	output logic [CHAN_W-1:0]   res_red
);

	logic [GRAY_SUM_W-1:0]  gray_sum;
	logic [GRAY_PROD_W-1:0] gray_prod;
	logic [CHAN_W-1:0]      gray;
	logic [CHAN_W:0]        sum_b;
	logic [CHAN_W:0]        sum_g;
	logic [CHAN_W:0]        sum_r;
	logic [CHAN_W-1:0]      add_b;
	logic [CHAN_W-1:0]      add_g;
	logic [CHAN_W-1:0]      add_r;

	always_comb begin
		gray_sum  = GRAY_SUM_W'(GRAY_B_K) * GRAY_SUM_W'(blue)
			+ GRAY_SUM_W'(GRAY_G_K) * GRAY_SUM_W'(green)
			+ GRAY_SUM_W'(GRAY_R_K) * GRAY_SUM_W'(red);
		gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(GRAY_RECIP);
		gray      = gray_prod[GRAY_SHIFT +: CHAN_W];

		sum_b = {1'b0, blue}  + {1'b0, weight};
		sum_g = {1'b0, green} + {1'b0, weight};
		sum_r = {1'b0, red}   + {1'b0, weight};
		add_b = (sum_b < {1'b0, CHAN_MAX}) ? sum_b[CHAN_W-1:0] : weight;
		add_g = (sum_g < {1'b0, CHAN_MAX}) ? sum_g[CHAN_W-1:0] : weight;
		add_r = (sum_r < {1'b0, CHAN_MAX}) ? sum_r[CHAN_W-1:0] : weight;

		res_blue  = blue;
		res_green = green;
		res_red   = red;
		case (filter)
			FILT_GRAY: begin
				if (weight != '0) begin
					res_blue  = gray;
					res_green = gray;
					res_red   = gray;
				end
			end
			FILT_BLUE:  res_blue  = add_b;
			FILT_GREEN: res_green = add_g;
			FILT_RED:   res_red   = add_r;
			default: begin
				res_blue = blue;
			end
		endcase
	end

endmodule

### hw/rtl/banded_color_pixel_filter.sv
// ----------------------------------------------------------------------------
// banded_color_pixel_filter
// Raster pixel filter choosing gray or a channel boost per column band.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: in_valid/in_stall with in_blue, in_green, in_red, one pixel
//   per transaction in raster order. Result channel: out_valid/out_stall with
//   out_blue, out_green, out_red and row_last, one result per pixel.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index (0 first
//   filter, 1 band width, 2 filter weight, 3 image width) and cfg_data;
//   cfg_ready is always high. Write only while no pixel is in flight.
//   There are two register stages: the input register takes the pixel at
//   its transaction edge, the filter logic feeds the result register, which
//   loads when it is empty or its result drains. Throughput is one pixel per
//   cycle while out_stall is low, set by the single filter stage; the column
//   tracker updates in the cycle of each pixel transaction.
//   Reset clears the pipeline, the column and band counters and loads the
//   register defaults (first filter 0, widths 1, weight 0).
//   A stalled result holds in the result register; the input register still
//   takes one more pixel if empty, then in_stall rises until the result drains.
// ----------------------------------------------------------------------------
module banded_color_pixel_filter import bcpf_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DAT_W-1:0]   cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CHAN_W-1:0]      in_blue,
	input  logic [CHAN_W-1:0]      in_green,
	input  logic [CHAN_W-1:0]      in_red,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CHAN_W-1:0]      out_blue,
	output logic [CHAN_W-1:0]      out_green,
	output logic [CHAN_W-1:0]      out_red,
	output logic                   row_last
);

	logic [FILT_W-1:0] first_filter_q;
	logic [DIM_W-1:0]  band_width_q;
	logic [CHAN_W-1:0] weight_q;
	logic [DIM_W-1:0]  image_width_q;
	logic              cfg_wr;
	logic              ff_wr;

	band_info_t        info;
	logic              in_acc;
	logic              ld_s1;
	logic              ld_s2;

	logic              valid_s1;
	logic [CHAN_W-1:0] blue_s1;
	logic [CHAN_W-1:0] green_s1;
	logic [CHAN_W-1:0] red_s1;
	band_info_t        info_s1;

	logic [CHAN_W-1:0] res_blue;
	logic [CHAN_W-1:0] res_green;
	logic [CHAN_W-1:0] res_red;

	logic              valid_s2;
	logic [CHAN_W-1:0] blue_s2;
	logic [CHAN_W-1:0] green_s2;
	logic [CHAN_W-1:0] red_s2;
	logic              last_s2;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign ff_wr     = cfg_wr && (cfg_reg_t'(cfg_index) == REG_FIRST_FILTER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_filter_q <= '0;
			band_width_q   <= DIM_W'(1);
			weight_q       <= '0;
			image_width_q  <= DIM_W'(1);
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_FIRST_FILTER:  first_filter_q <= cfg_data[FILT_W-1:0];
				REG_BAND_WIDTH:    band_width_q   <= cfg_data;
				REG_FILTER_WEIGHT: weight_q       <= cfg_data[CHAN_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q  <= cfg_data;
				default:           weight_q       <= weight_q;
			endcase
		end
	end

	assign ld_s2    = !valid_s2 || !out_stall;
	assign ld_s1    = !valid_s1 || ld_s2;
	assign in_stall = !ld_s1;
	assign in_acc   = in_valid && ld_s1;

	bcpf_band_track #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (in_acc),
		.ff_wr        (ff_wr),
		.ff_data      (cfg_data[FILT_W-1:0]),
		.first_filter (first_filter_q),
		.band_width   (band_width_q),
		.image_width  (image_width_q),
		.info         (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ld_s1) begin
				valid_s1 <= in_valid;
			end
			if (ld_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blue_s1  <= in_blue;
			green_s1 <= in_green;
			red_s1   <= in_red;
			info_s1  <= info;
		end
	end

	bcpf_color u_color (
		.filter    (info_s1.filter),
		.weight    (weight_q),
		.blue      (blue_s1),
		.green     (green_s1),
		.red       (red_s1),
		.res_blue  (res_blue),
		.res_green (res_green),
		.res_red   (res_red)
	);

	always_ff @(posedge clk) begin
		if (ld_s2 && valid_s1) begin
			blue_s2  <= res_blue;
			green_s2 <= res_green;
			red_s2   <= res_red;
			last_s2  <= info_s1.last;
		end
	end

	assign out_valid = valid_s2;
	assign out_blue  = blue_s2;
	assign out_green = green_s2;
	assign out_red   = red_s2;
	assign row_last  = last_s2;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while the pipeline can move");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ld_s2) |=> (valid_s1 && $stable(blue_s1) && $stable(info_s1)))
		else $error("held input register lost or changed its pixel");

	a_out_drop_only_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without a transaction");
`endif

endmodule
